FILE: src/vftl_pkg.sv
// ----------------------------------------------------------------------------
// vftl_pkg
// Shared types and constants of the vector field trilinear lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

package vftl_pkg;

  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_X_MIN       = 3'd0;
  localparam reg_idx_t REG_Y_MIN       = 3'd1;
  localparam reg_idx_t REG_Z_MIN       = 3'd2;
  localparam reg_idx_t REG_X_INV_STEP  = 3'd3;
  localparam reg_idx_t REG_Y_INV_STEP  = 3'd4;
  localparam reg_idx_t REG_Z_INV_STEP  = 3'd5;
  localparam reg_idx_t REG_FIELD_SCALE = 3'd6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic signed [23:0] SCALE_ONE = 24'sd65536;

  typedef logic [1:0] axis_t;
  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;

  typedef logic [2:0] step_t;
  localparam step_t STEP_X00 = 3'd0;
  localparam step_t STEP_X01 = 3'd1;
  localparam step_t STEP_X10 = 3'd2;
  localparam step_t STEP_X11 = 3'd3;
  localparam step_t STEP_Y0  = 3'd4;
  localparam step_t STEP_Y1  = 3'd5;
  localparam step_t STEP_Z   = 3'd6;

  localparam logic [3:0] RD_LAST = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AX_LO,
    ST_AX_HI,
    ST_AX_ACC,
    ST_RD,
    ST_LRP_MUL,
    ST_LRP_ADD,
    ST_SCL,
    ST_FIN
  } vftl_state_t;

  typedef struct packed {
    logic       start;
    logic       load;
    axis_t      axis;
    logic       ax_lo;
    logic       ax_hi;
    logic       ax_acc;
    logic       rd_en;
    logic [2:0] rd_corner;
    logic       cap_en;
    logic [2:0] cap_corner;
    logic       lrp_mul;
    logic       lrp_add;
    step_t      step;
    logic       scl;
    logic       out_load;
  } vftl_cmd_t;

  typedef struct packed {
    logic axis_out;
  } vftl_sts_t;

endpackage

`default_nettype wire

FILE: src/vftl_if.sv
// ----------------------------------------------------------------------------
// vftl interfaces
// Input, result and configuration channels of the lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

interface vftl_in_if import vftl_pkg::*;;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [4:0]         load_ix;
  logic [4:0]         load_iy;
  logic [4:0]         load_iz;
  logic signed [23:0] sample_bx;
  logic signed [23:0] sample_by;
  logic signed [23:0] sample_bz;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (
    output valid, operation, load_ix, load_iy, load_iz,
    output sample_bx, sample_by, sample_bz, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, operation, load_ix, load_iy, load_iz,
    input  sample_bx, sample_by, sample_bz, point_x, point_y, point_z,
    output ready
  );
endinterface

interface vftl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_field_x;
  logic signed [31:0] out_field_y;
  logic signed [31:0] out_field_z;
  logic               outside;

  modport source (
    output valid, out_field_x, out_field_y, out_field_z, outside,
    input  ready
  );
  modport sink (
    input  valid, out_field_x, out_field_y, out_field_z, outside,
    output ready
  );
endinterface

interface vftl_cfg_if import vftl_pkg::*;;
  logic        valid;
  logic        ready;
  reg_idx_t    index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/vector_field_trilinear_lookup_core.sv
// ----------------------------------------------------------------------------
// vector_field_trilinear_lookup_core
// 3-D grid of field samples with trilinear interpolation and scaling.
// ----------------------------------------------------------------------------
// load: written into the grid store at the accepting edge
// inside query: each axis on one 16x32 multiplier (low half, high half, sum),
//   the eight corner reads of the store, then a multiply and add per lerp step
// outside query: ends at the first axis found out of range
// one item in flight; the result register frees the input side at once
// reset clears control and config registers; grid store holds no reset value
`default_nettype none

module vector_field_trilinear_lookup_core import vftl_pkg::*; #(
  parameter int GRID_POINTS_X = 32,
  parameter int GRID_POINTS_Y = 32,
  parameter int GRID_POINTS_Z = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  vftl_in_if.sink      in_ch,
  vftl_out_if.source   out_ch,
  vftl_cfg_if.sink     cfg_ch
);

  vftl_cmd_t cmd;
  vftl_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  vftl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_operation(in_ch.operation),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  vftl_dp #(
    .GRID_POINTS_X(GRID_POINTS_X),
    .GRID_POINTS_Y(GRID_POINTS_Y),
    .GRID_POINTS_Z(GRID_POINTS_Z)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .load_ix    (in_ch.load_ix),
    .load_iy    (in_ch.load_iy),
    .load_iz    (in_ch.load_iz),
    .sample_bx  (in_ch.sample_bx),
    .sample_by  (in_ch.sample_by),
    .sample_bz  (in_ch.sample_bz),
    .point_x    (in_ch.point_x),
    .point_y    (in_ch.point_y),
    .point_z    (in_ch.point_z),
    .out_field_x(out_ch.out_field_x),
    .out_field_y(out_ch.out_field_y),
    .out_field_z(out_ch.out_field_z),
    .outside    (out_ch.outside)
  );

endmodule

`default_nettype wire

FILE: src/vftl_ram.sv
// ----------------------------------------------------------------------------
// vftl_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vftl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/vftl_ctrl.sv
// ----------------------------------------------------------------------------
// vftl_ctrl
// Sequencer: axis mapping, corner reads, lerp steps, scaling, result hold.
// ----------------------------------------------------------------------------
`default_nettype none

module vftl_ctrl import vftl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_operation,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  vftl_sts_t sts,
  output vftl_cmd_t cmd
);

  vftl_state_t state_r, state_nxt;
  axis_t       ax_r, ax_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ax_r        <= AX_X;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    ax_nxt         = ax_r;
    cnt_nxt        = cnt_r;
    cmd            = '0;
    cmd.axis       = ax_r;
    cmd.rd_corner  = cnt_r[2:0];
    cmd.cap_corner = cnt_r[2:0] - 3'd1;
    cmd.step       = cnt_r[2:0];
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_operation == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            ax_nxt    = AX_X;
            state_nxt = ST_AX_LO;
          end
        end
      end
      ST_AX_LO: begin
        cmd.ax_lo = 1'b1;
        state_nxt = ST_AX_HI;
      end
      ST_AX_HI: begin
        cmd.ax_hi = 1'b1;
        state_nxt = ST_AX_ACC;
      end
      ST_AX_ACC: begin
        cmd.ax_acc = 1'b1;
        if (sts.axis_out) begin
          state_nxt = ST_FIN;
        end else if (ax_r == AX_Z) begin
          cnt_nxt   = '0;
          state_nxt = ST_RD;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = ST_AX_LO;
        end
      end
      ST_RD: begin
        cmd.rd_en  = (cnt_r != RD_LAST);
        cmd.cap_en = (cnt_r != '0);
        if (cnt_r == RD_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_LRP_MUL;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_LRP_MUL: begin
        cmd.lrp_mul = 1'b1;
        state_nxt   = ST_LRP_ADD;
      end
      ST_LRP_ADD: begin
        cmd.lrp_add = 1'b1;
        if (cnt_r[2:0] == STEP_Z) begin
          state_nxt = ST_SCL;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = ST_LRP_MUL;
        end
      end
      ST_SCL: begin
        cmd.scl   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: src/vftl_dp.sv
// ----------------------------------------------------------------------------
// vftl_dp
// Datapath: config registers, grid stores, axis mapping, lerp lanes, scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module vftl_dp import vftl_pkg::*; #(
  parameter int GRID_POINTS_X = 32,
  parameter int GRID_POINTS_Y = 32,
  parameter int GRID_POINTS_Z = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vftl_cmd_t          cmd,
  output vftl_sts_t          sts,
  input  logic               cfg_we,
  input  reg_idx_t           cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [4:0]         load_ix,
  input  logic [4:0]         load_iy,
  input  logic [4:0]         load_iz,
  input  logic signed [23:0] sample_bx,
  input  logic signed [23:0] sample_by,
  input  logic signed [23:0] sample_bz,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic signed [31:0] out_field_x,
  output logic signed [31:0] out_field_y,
  output logic signed [31:0] out_field_z,
  output logic               outside
);

  localparam int IXW   = $clog2(GRID_POINTS_X);
  localparam int IYW   = $clog2(GRID_POINTS_Y);
  localparam int IZW   = $clog2(GRID_POINTS_Z);
  localparam int DEPTH = GRID_POINTS_X * GRID_POINTS_Y * GRID_POINTS_Z;
  localparam int AW    = $clog2(DEPTH);

  logic signed [31:0] x_min_r, y_min_r, z_min_r;
  logic [31:0]        x_inv_r, y_inv_r, z_inv_r;
  logic signed [23:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= '0;
      y_min_r <= '0;
      z_min_r <= '0;
      x_inv_r <= '0;
      y_inv_r <= '0;
      z_inv_r <= '0;
      scale_r <= SCALE_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_MIN:       x_min_r <= cfg_data;
        REG_Y_MIN:       y_min_r <= cfg_data;
        REG_Z_MIN:       z_min_r <= cfg_data;
        REG_X_INV_STEP:  x_inv_r <= cfg_data;
        REG_Y_INV_STEP:  y_inv_r <= cfg_data;
        REG_Z_INV_STEP:  z_inv_r <= cfg_data;
        REG_FIELD_SCALE: scale_r <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  // query point latch
  logic signed [31:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r <= point_x;
      py_r <= point_y;
      pz_r <= point_z;
    end
  end

  // axis mapping
  logic signed [31:0] p_sel, m_sel;
  logic [31:0]        inv_sel;
  logic [32:0]        lim_sel;
  logic signed [32:0] d;
  logic [15:0]        mop;
  logic [47:0]        mprod;
  logic [47:0]        plo_r, phi_r;
  logic [64:0]        full;
  logic [32:0]        cell_idx;
  logic [15:0]        frac;

  always_comb begin
    case (cmd.axis)
      AX_Y: begin
        p_sel   = py_r;
        m_sel   = y_min_r;
        inv_sel = y_inv_r;
        lim_sel = 33'(GRID_POINTS_Y - 1);
      end
      AX_Z: begin
        p_sel   = pz_r;
        m_sel   = z_min_r;
        inv_sel = z_inv_r;
        lim_sel = 33'(GRID_POINTS_Z - 1);
      end
      default: begin
        p_sel   = px_r;
        m_sel   = x_min_r;
        inv_sel = x_inv_r;
        lim_sel = 33'(GRID_POINTS_X - 1);
      end
    endcase
  end

  assign d        = {p_sel[31], p_sel} - {m_sel[31], m_sel};
  assign mop      = cmd.ax_hi ? d[31:16] : d[15:0];
  assign mprod    = 48'(mop) * 48'(inv_sel);
  assign full     = 65'(plo_r) + 65'({phi_r, 16'h0000});
  assign cell_idx = full[64:32];
  assign frac     = full[31:16];

  assign sts.axis_out = d[32] | (cell_idx >= lim_sel);

  logic [IXW-1:0] ix_r;
  logic [IYW-1:0] iy_r;
  logic [IZW-1:0] iz_r;
  logic [15:0]    fx_r, fy_r, fz_r;
  logic           outside_r;

  always_ff @(posedge clk) begin
    if (cmd.ax_lo) begin
      plo_r <= mprod;
    end
    if (cmd.ax_hi) begin
      phi_r <= mprod;
    end
    if (cmd.ax_acc) begin
      case (cmd.axis)
        AX_Y: begin
          iy_r <= IYW'(cell_idx);
          fy_r <= frac;
        end
        AX_Z: begin
          iz_r <= IZW'(cell_idx);
          fz_r <= frac;
        end
        default: begin
          ix_r <= IXW'(cell_idx);
          fx_r <= frac;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outside_r <= 1'b0;
    end else if (cmd.start) begin
      outside_r <= 1'b0;
    end else if (cmd.ax_acc && sts.axis_out) begin
      outside_r <= 1'b1;
    end
  end

  // store addressing
  logic           load_ok;
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [IXW-1:0] rx;
  logic [IYW-1:0] ry;
  logic [IZW-1:0] rz;

  assign load_ok = (32'(load_ix) < GRID_POINTS_X) && (32'(load_iy) < GRID_POINTS_Y)
                && (32'(load_iz) < GRID_POINTS_Z);
  assign we      = cmd.load & load_ok;
  assign waddr   = (AW'(load_ix) * AW'(GRID_POINTS_Y) + AW'(load_iy)) * AW'(GRID_POINTS_Z)
                 + AW'(load_iz);

  // corner bits: x in bit 0, z in bit 1, y in bit 2
  assign rx    = ix_r + IXW'(cmd.rd_corner[0]);
  assign rz    = iz_r + IZW'(cmd.rd_corner[1]);
  assign ry    = iy_r + IYW'(cmd.rd_corner[2]);
  assign raddr = (AW'(rx) * AW'(GRID_POINTS_Y) + AW'(ry)) * AW'(GRID_POINTS_Z) + AW'(rz);

  logic signed [23:0] smp [3];
  logic signed [31:0] res [3];

  assign smp[0] = sample_bx;
  assign smp[1] = sample_by;
  assign smp[2] = sample_bz;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [23:0] rdata;
    logic signed [23:0] c_r [8];
    logic signed [23:0] t_r [7];
    logic signed [23:0] a, b;
    logic [15:0]        f;
    logic signed [24:0] dif;
    logic signed [41:0] pr_r;
    logic signed [23:0] a_r;
    logic signed [42:0] s;
    logic signed [47:0] sp_r;
    logic signed [48:0] r49;
    logic signed [32:0] rs;

    vftl_ram #(
      .WIDTH(24),
      .DEPTH(DEPTH)
    ) u_store (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(smp[l]),
      .re   (cmd.rd_en),
      .raddr(raddr),
      .rdata(rdata)
    );

    always_comb begin
      case (cmd.step)
        STEP_X00: begin a = c_r[0]; b = c_r[1]; f = fx_r; end
        STEP_X01: begin a = c_r[2]; b = c_r[3]; f = fx_r; end
        STEP_X10: begin a = c_r[4]; b = c_r[5]; f = fx_r; end
        STEP_X11: begin a = c_r[6]; b = c_r[7]; f = fx_r; end
        STEP_Y0:  begin a = t_r[0]; b = t_r[2]; f = fy_r; end
        STEP_Y1:  begin a = t_r[1]; b = t_r[3]; f = fy_r; end
        default:  begin a = t_r[4]; b = t_r[5]; f = fz_r; end
      endcase
    end

    assign dif = {b[23], b} - {a[23], a};
    assign s   = $signed({{3{a_r[23]}}, a_r, 16'h0000}) + 43'(pr_r) + 43'sd32768;
    assign r49 = 49'(sp_r) + 49'sd32768;
    assign rs  = r49[48:16];

    always_ff @(posedge clk) begin
      if (cmd.cap_en) begin
        c_r[cmd.cap_corner] <= rdata;
      end
      if (cmd.lrp_mul) begin
        pr_r <= 42'(dif) * 42'($signed({1'b0, f}));
        a_r  <= a;
      end
      if (cmd.lrp_add) begin
        t_r[cmd.step] <= s[39:16];
      end
      if (cmd.scl) begin
        sp_r <= 48'(t_r[6]) * 48'(scale_r);
      end
    end

    always_comb begin
      if (rs > 33'sd2147483647) begin
        res[l] = 32'sh7fffffff;
      end else if (rs < -33'sd2147483648) begin
        res[l] = 32'sh80000000;
      end else begin
        res[l] = rs[31:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_field_x <= outside_r ? '0 : res[0];
      out_field_y <= outside_r ? '0 : res[1];
      out_field_z <= outside_r ? '0 : res[2];
      outside     <= outside_r;
    end
  end

endmodule

`default_nettype wire

FILE: src/vftl_chk.sv
// ----------------------------------------------------------------------------
// vftl_chk
// Port-level checks of the lookup core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vftl_chk import vftl_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_operation,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] out_field_x,
  input wire logic signed [31:0] out_field_y,
  input wire logic signed [31:0] out_field_z,
  input wire logic               outside
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && outside |-> out_field_x == 0 && out_field_y == 0 && out_field_z == 0)
    else $error("outside result carries a nonzero field");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_QUERY |=> !in_ready)
    else $error("input taken while a query is in work");

endmodule

bind vector_field_trilinear_lookup_core vftl_chk u_vftl_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_operation(in_ch.operation),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_field_x (out_ch.out_field_x),
  .out_field_y (out_ch.out_field_y),
  .out_field_z (out_ch.out_field_z),
  .outside     (out_ch.outside)
);

`default_nettype wire

FILE: tb/vftl_checker.sv
// ----------------------------------------------------------------------------
// vftl_checker
// Watches the input, result and configuration channels of the lookup core,
// keeps its own grid store and register copy, works out the field for each
// query transfer and compares every result transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module vftl_checker import vftl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  vftl_in_if   in_ch,
  vftl_out_if  out_ch,
  vftl_cfg_if  cfg_ch,
  output int   errors,
  output int   pending
);

  localparam int NPTS = 32;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic               outside;
  } field_result_t;

  field_result_t field_q[$];

  logic signed [31:0] org_x, org_y, org_z;
  logic        [31:0] inv_x, inv_y, inv_z;
  logic signed [23:0] scale;

  logic signed [23:0] mem_bx [0:NPTS*NPTS*NPTS-1];
  logic signed [23:0] mem_by [0:NPTS*NPTS*NPTS-1];
  logic signed [23:0] mem_bz [0:NPTS*NPTS*NPTS-1];

  function automatic bit locate(input logic signed [31:0] p, input logic signed [31:0] org,
                                input logic [31:0] inv, output int cidx, output int frac);
    longint      d;
    logic [64:0] prod;
    d = longint'(p) - longint'(org);
    cidx = 0;
    frac = 0;
    if (d < 0) return 0;
    prod = 65'(d) * 65'(inv);
    if (prod[64:32] >= NPTS - 1) return 0;
    cidx = int'(prod[36:32]);
    frac = int'(prod[31:16]);
    return 1;
  endfunction

  function automatic longint lerp(input longint a, input longint b, input int f);
    longint s;
    s = a * (65536 - f) + b * f + 32768;
    return s >>> 16;
  endfunction

  function automatic longint sample_at(input int comp, input int ix, input int iy, input int iz);
    int a;
    a = (ix * NPTS + iy) * NPTS + iz;
    case (comp)
      0: return longint'(mem_bx[a]);
      1: return longint'(mem_by[a]);
      default: return longint'(mem_bz[a]);
    endcase
  endfunction

  function automatic logic signed [31:0] field_of(input int comp, input int ix, input int iy,
                                                   input int iz, input int fx, input int fy,
                                                   input int fz);
    longint c00, c01, c10, c11, c0, c1, v, r;
    c00 = lerp(sample_at(comp, ix, iy, iz), sample_at(comp, ix+1, iy, iz), fx);
    c01 = lerp(sample_at(comp, ix, iy, iz+1), sample_at(comp, ix+1, iy, iz+1), fx);
    c10 = lerp(sample_at(comp, ix, iy+1, iz), sample_at(comp, ix+1, iy+1, iz), fx);
    c11 = lerp(sample_at(comp, ix, iy+1, iz+1), sample_at(comp, ix+1, iy+1, iz+1), fx);
    c0 = lerp(c00, c10, fy);
    c1 = lerp(c01, c11, fy);
    v = lerp(c0, c1, fz);
    r = (v * longint'(scale) + 32768) >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic field_result_t predict_field(input logic signed [31:0] px,
                                                  input logic signed [31:0] py,
                                                  input logic signed [31:0] pz);
    field_result_t res;
    int ix, iy, iz, fx, fy, fz;
    bit hit;
    hit = locate(px, org_x, inv_x, ix, fx);
    hit = hit && locate(py, org_y, inv_y, iy, fy);
    hit = hit && locate(pz, org_z, inv_z, iz, fz);
    res = '{fx: 0, fy: 0, fz: 0, outside: 1'b1};
    if (hit) begin
      res.fx = field_of(0, ix, iy, iz, fx, fy, fz);
      res.fy = field_of(1, ix, iy, iz, fx, fy, fz);
      res.fz = field_of(2, ix, iy, iz, fx, fy, fz);
      res.outside = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      org_x <= '0;
      org_y <= '0;
      org_z <= '0;
      inv_x <= '0;
      inv_y <= '0;
      inv_z <= '0;
      scale <= SCALE_ONE;
      field_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_X_MIN:       org_x <= cfg_ch.data;
          REG_Y_MIN:       org_y <= cfg_ch.data;
          REG_Z_MIN:       org_z <= cfg_ch.data;
          REG_X_INV_STEP:  inv_x <= cfg_ch.data;
          REG_Y_INV_STEP:  inv_y <= cfg_ch.data;
          REG_Z_INV_STEP:  inv_z <= cfg_ch.data;
          REG_FIELD_SCALE: scale <= cfg_ch.data[23:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_LOAD) begin
          mem_bx[(in_ch.load_ix * NPTS + in_ch.load_iy) * NPTS + in_ch.load_iz] = in_ch.sample_bx;
          mem_by[(in_ch.load_ix * NPTS + in_ch.load_iy) * NPTS + in_ch.load_iz] = in_ch.sample_by;
          mem_bz[(in_ch.load_ix * NPTS + in_ch.load_iy) * NPTS + in_ch.load_iz] = in_ch.sample_bz;
        end else begin
          field_q.insert(field_q.size(),
                         predict_field(in_ch.point_x, in_ch.point_y, in_ch.point_z));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (field_q.size() == 0) begin
          $error("result transfer with no query waiting");
          errors++;
        end else begin
          field_result_t exp_r;
          exp_r = field_q.pop_front();
          if (out_ch.out_field_x !== exp_r.fx) begin
            $error("out_field_x expected %0d got %0d", exp_r.fx, out_ch.out_field_x);
            errors++;
          end
          if (out_ch.out_field_y !== exp_r.fy) begin
            $error("out_field_y expected %0d got %0d", exp_r.fy, out_ch.out_field_y);
            errors++;
          end
          if (out_ch.out_field_z !== exp_r.fz) begin
            $error("out_field_z expected %0d got %0d", exp_r.fz, out_ch.out_field_z);
            errors++;
          end
          if (out_ch.outside !== exp_r.outside) begin
            $error("outside expected %0d got %0d", exp_r.outside, out_ch.outside);
            errors++;
          end
        end
      end
      pending = field_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the vector field lookup core: a directed opening
// on the reset settings, then phases of grid loads and aimed and random
// queries under several register settings; both sides stall at random but in the last phase.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import vftl_pkg::*;;

  localparam int NPTS        = 32;
  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst_n;
  bit   calm;
  int   cycles;
  int   errors;
  int   pending;
  int   n_load, n_query, n_aimed;
  int   stall_left;

  bit   loaded [0:NPTS*NPTS*NPTS-1];

  logic signed [31:0] org [3];
  logic        [31:0] inv [3];

  vftl_in_if  in_ch ();
  vftl_out_if out_ch ();
  vftl_cfg_if cfg_ch ();

  vector_field_trilinear_lookup_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  vftl_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side back pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(input logic op, input logic [4:0] ix, input logic [4:0] iy,
                           input logic [4:0] iz, input logic signed [23:0] bx,
                           input logic signed [23:0] by, input logic signed [23:0] bz,
                           input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [31:0] pz);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.load_ix   <= ix;
    in_ch.load_iy   <= iy;
    in_ch.load_iz   <= iz;
    in_ch.sample_bx <= bx;
    in_ch.sample_by <= by;
    in_ch.sample_bz <= bz;
    in_ch.point_x   <= px;
    in_ch.point_y   <= py;
    in_ch.point_z   <= pz;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_LOAD) begin
      loaded[(ix * NPTS + iy) * NPTS + iz] = 1'b1;
      n_load++;
    end else begin
      n_query++;
    end
  endtask

  task automatic load_point(input int ix, input int iy, input int iz,
                            input logic signed [23:0] bx, input logic signed [23:0] by,
                            input logic signed [23:0] bz);
    send_item(OP_LOAD, 5'(ix), 5'(iy), 5'(iz), bx, by, bz, $urandom, $urandom, $urandom);
  endtask

  task automatic load_random();
    load_point($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
               24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  // true when the query is outside or all eight corners have been loaded
  function automatic bit corners_ready(input logic signed [31:0] p [3]);
    longint      d;
    logic [64:0] prod;
    int          c [3];
    for (int a = 0; a < 3; a++) begin
      d = longint'(p[a]) - longint'(org[a]);
      if (d < 0) return 1;
      prod = 65'(d) * 65'(inv[a]);
      if (prod[64:32] >= NPTS - 1) return 1;
      c[a] = int'(prod[36:32]);
    end
    for (int k = 0; k < 8; k++) begin
      if (!loaded[((c[0] + k[0]) * NPTS + c[1] + k[1]) * NPTS + c[2] + k[2]]) return 0;
    end
    return 1;
  endfunction

  task automatic query_point(input logic signed [31:0] p [3]);
    logic signed [31:0] q [3];
    q = p;
    if (!corners_ready(q)) q = org;
    send_item(OP_QUERY, 5'($urandom), 5'($urandom), 5'($urandom),
              24'($urandom), 24'($urandom), 24'($urandom), q[0], q[1], q[2]);
  endtask

  // aim at a cell of one of the loaded corner blocks, or just past the grid
  task automatic query_aimed();
    logic signed [31:0] p [3];
    longint off, pt;
    int base;
    base = $urandom_range(0, 1) ? 28 : 0;
    for (int a = 0; a < 3; a++) begin
      int c;
      c = base + $urandom_range(0, 2);
      if ($urandom_range(0, 19) == 0) c = 31;
      if (inv[a] == 0) off = $urandom_range(0, 1000);
      else off = ((longint'(c) <<< 32) + longint'($urandom_range(0, 32'hffff) << 16)
                  + $urandom_range(0, 32'hffff)) / longint'({32'b0, inv[a]});
      pt = longint'(org[a]) + off;
      p[a] = (pt > 64'sd2147483647) ? org[a] : pt[31:0];
    end
    n_aimed++;
    query_point(p);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_grid(input logic signed [31:0] ox, input logic signed [31:0] oy,
                          input logic signed [31:0] oz, input logic [31:0] sx,
                          input logic [31:0] sy, input logic [31:0] sz,
                          input logic signed [23:0] scl);
    drain();
    write_reg(REG_X_MIN, ox);
    write_reg(REG_Y_MIN, oy);
    write_reg(REG_Z_MIN, oz);
    write_reg(REG_X_INV_STEP, sx);
    write_reg(REG_Y_INV_STEP, sy);
    write_reg(REG_Z_INV_STEP, sz);
    write_reg(REG_FIELD_SCALE, {{8{scl[23]}}, scl});
    org = '{ox, oy, oz};
    inv = '{sx, sy, sz};
  endtask

  task automatic run_mix(input int count);
    logic signed [31:0] p [3];
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        load_random();
      end else if (pick < 38) begin
        p = '{$urandom, $urandom, $urandom};
        query_point(p);
      end else begin
        query_aimed();
      end
    end
  endtask

  initial begin
    logic signed [31:0] p [3];
    rst_n        = 1'b0;
    calm         = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.operation = OP_LOAD;
    in_ch.load_ix = '0;
    in_ch.load_iy = '0;
    in_ch.load_iz = '0;
    in_ch.sample_bx = '0;
    in_ch.sample_by = '0;
    in_ch.sample_bz = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_X_MIN;
    cfg_ch.data  = '0;
    org = '{0, 0, 0};
    inv = '{0, 0, 0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: every point at or above origin lands on cell 0
    load_point(0, 0, 0, 24'sh7fffff, 24'sh800000, 24'sh000000);
    load_point(1, 0, 0, 24'sh800000, 24'sh7fffff, -24'sd1);
    load_point(0, 1, 0, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    load_point(1, 1, 0, 24'sh800000, 24'sh800000, 24'sh800000);
    load_point(0, 0, 1, 24'sd1, -24'sd1, 24'sd0);
    load_point(1, 0, 1, 24'sd12345, -24'sd54321, 24'sh7fffff);
    load_point(0, 1, 1, 24'sh800000, 24'sd0, 24'sd1);
    load_point(1, 1, 1, 24'sd0, 24'sh7fffff, 24'sh800000);
    load_point(31, 31, 31, 24'sh7fffff, 24'sh800000, 24'sh555555);
    p = '{0, 0, 0};
    query_point(p);
    p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    query_point(p);
    p = '{-1, 0, 0};
    query_point(p);
    p = '{0, 0, 32'sh80000000};
    query_point(p);
    p = '{0, -1, 5};
    query_point(p);

    // corner blocks at both ends of the grid
    set_grid(0, 0, 0, 32'd4294967, 32'd4294967, 32'd4294967, SCALE_ONE);
    for (int b = 0; b < 2; b++)
      for (int x = 0; x < 4; x++)
        for (int y = 0; y < 4; y++)
          for (int z = 0; z < 4; z++)
            load_point(b * 28 + x, b * 28 + y, b * 28 + z,
                       24'($urandom), 24'($urandom), 24'($urandom));
    run_mix(100);

    set_grid(32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'hffffffff, 32'hffffffff, 32'hffffffff, 24'sh7fffff);
    run_mix(90);
    set_grid(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
             $urandom, $urandom, $urandom, 24'sh800000);
    run_mix(40);
    set_grid(-32'sd5000, 32'sd777, 32'sd123456, 32'd85899346, 32'd42949673, 32'd17179869,
             -24'sd65536);
    run_mix(100);
    set_grid($urandom, $urandom, $urandom, $urandom_range(1, 32'h3fffff),
             $urandom_range(1, 32'h3fffff), $urandom_range(1, 32'h3fffff), 24'($urandom));
    run_mix(100);
    set_grid($urandom_range(0, 100000) - 50000, $urandom_range(0, 100000) - 50000,
             $urandom_range(0, 100000) - 50000, $urandom_range(1 << 20, 1 << 24),
             $urandom_range(1 << 20, 1 << 24), $urandom_range(1 << 20, 1 << 24),
             24'($urandom));
    calm = 1'b1;
    run_mix(120);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("ran %0d loads and %0d queries (%0d aimed at loaded cells)",
             n_load, n_query, n_aimed);
    $display("over seven register settings, with stalls on both channels");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
src/vftl_pkg.sv
src/vftl_if.sv
src/vftl_ram.sv
src/vftl_ctrl.sv
src/vftl_dp.sv
src/vector_field_trilinear_lookup_core.sv
src/vftl_chk.sv
tb/vftl_checker.sv
tb/testbench.sv
